// ===== sv/zns_pkg.sv =====
// Shared types, layer tables and fixed-point constants of the ziggurat normal sampler.
package zns_pkg;

  localparam int unsigned NUM_LAYERS = 128;
  localparam int unsigned LAYER_W    = 7;
  localparam int unsigned MUL_W      = 35;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [LAYER_W-1:0] LAST_LAYER = LAYER_W'(NUM_LAYERS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MEAN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 1'b1;

  localparam logic [31:0] SPREAD_RESET = 32'd65536;

  // Decimal constants are held scaled by 10^18.
  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

  typedef logic [63:0] dec_t [NUM_LAYERS];
  typedef logic [31:0] rom_t [NUM_LAYERS];

  localparam dec_t XDEC = '{
    64'd0,64'd272320864704663850,64'd362871431028418304,64'd426547986303305124,
    64'd477437837253787876,64'd520656038725144917,64'd558692178375517971,64'd592962942441977979,
    64'd624358597309088221,64'd653478638715042387,64'd680747918645904216,64'd706479611313608034,
    64'd730911910621881281,64'd754230664434510071,64'd776583987876148386,64'd798092060626274804,
    64'd818853906683317723,64'd838952214281207455,64'd858456843178050863,64'd877427429097715691,
    64'd895915352566238529,64'd913965251008801776,64'd931616196601353810,64'd948902625497911954,
    64'd965855079388130595,64'd982500803502760385,64'd998864233480643513,64'd1014967395239299470,
    64'd1030830236056455590,64'd1046470900752580260,64'd1061905963683619400,
    64'd1077150624881937650,64'd1092218876896553760,64'd1107123647523535390,
    64'd1121876922572254060,64'd1136489852003075530,64'd1150972842138976060,
    64'd1165335636155046900,64'd1179587384654460700,64'd1193736707823772190,
    64'd1207791750406757600,64'd1221760230530962560,64'd1235649483254481170,
    64'd1249466499564333740,64'd1263217961446028230,64'd1276910273551699710,
    64'd1290549591917873150,64'd1304141850120421530,64'd1317692783201342990,
    64'd1331207949657676500,64'd1344692751745713040,64'd1358152454322422870,
    64'd1371592202419732270,64'd1385017037725148640,64'd1398431914123606350,
    64'd1411841712439760250,64'd1425251254506861570,64'd1438665316677461310,
    64'd1452088642882216490,64'd1465525957335794620,64'd1478981976983097850,
    64'd1492461423774615400,64'd1505969036856550260,64'd1519509584759370780,
    64'd1533087877667556070,64'd1546708779853503460,64'd1560377222359840680,
    64'd1574098216016749720,64'd1587876864884400700,64'd1601718380215277050,
    64'd1615628095037132960,64'd1629611479464678390,64'd1643674156856982640,
    64'd1657821920948207540,64'd1672060754091852200,64'd1686396846773486320,
    64'd1700836618564300940,64'd1715386740708116540,64'd1730054160558243530,
    64'd1744846128108376500,64'd1759770224894231870,64'd1774834395580769240,
    64'd1790046982594618980,64'd1805416764214048740,64'd1820952996591005070,
    64'd1836665460253384040,64'd1852564511723087060,64'd1868661140989542000,
    64'd1884967035702869230,64'd1901494653100317610,64'd1918257300859732030,
    64'd1935269228291900200,64'd1952545729548888900,64'd1970103260849713220,
    64'd1987959574123060720,64'd2006133869958966840,64'd2024646973372933870,
    64'd2043521536650669490,64'd2062782274503963350,64'd2082456237987724640,
    64'd2102573135184998880,64'd2123165708669789960,64'd2144270182356261350,
    64'd2165926793744840730,64'd2188180432072020600,64'd2211081408874727810,
    64'd2234686395587056980,64'd2259059573865329520,64'd2284274059673656800,
    64'd2310413683695002150,64'd2337575241335530730,64'd2365871370113987540,
    64'd2395434278007467340,64'd2426420645530211590,64'd2459018177408350090,
    64'd2493454522091950760,64'd2530009672385466610,64'd2569033625921639130,
    64'd2610972248428613200,64'd2656406411258192500,64'd2706113573118722330,
    64'd2761169372384153850,64'd2823125350545966430,64'd2894344007018670620,
    64'd2978696252645016960,64'd3083228858214213700,64'd3223084984578618540,
    64'd3442619855896652120
  };

  localparam dec_t YDEC = '{
    64'd398942280401432678,64'd384420658981682726,64'd373522748141106316,64'd364251715035986642,
    64'd355968876531425490,64'd348373573283578819,64'd341295363394479423,64'd334626244265964860,
    64'd328292479472809649,64'd322240957253635010,64'd316431845843046832,64'd310834316291433707,
    64'd305423896178597626,64'd300180751490354248,64'd295088526356077135,64'd290133533446065115,
    64'd285304173202847215,64'd280590507234007472,64'd275983938443315368,64'd271476966845668090,
    64'd267063000179495015,64'd262736204934735768,64'd258491387684491830,64'd254323899476874075,
    64'd250229558010610547,64'd246204583692175839,64'd242245546648512680,64'd238349322473737380,
    64'd234513055003481010,64'd230734124792334072,64'd227010122256156323,64'd223338824658038588,
    64'd219718176282891875,64'd216146271274101058,64'd212621338705853685,64'd209141729543510392,
    64'd205705905206777190,64'd202312427500227481,64'd198959949715719394,64'd195647208743592170,
    64'd192373018055828097,64'd189136261445882234,64'd185935887427576882,64'd182770904210084495,
    64'd179640375178172028,64'd176543414817017910,64'd173479185029409926,64'd170446891800283875,
    64'd167445782169606159,64'd164475141479729723,64'd161534290867717281,64'd158622584976854697,
    64'd155739409864774326,64'd152884181088357758,64'd150056341947960011,64'd147255361875550651,
    64'd144480734953149976,64'd141731978549490419,64'd139008632064188530,64'd136310255769899547,
    64'd133636429743968693,64'd130986752882010972,64'd128360841986661826,64'd125758330925458934,
    64'd123178869852453437,64'd120622124488717524,64'd118087775457424043,64'd115575517669630454,
    64'd113085059757311182,64'd110616123550555179,64'd108168443596184749,64'd105741766715362132,
    64'd103335851598036258,64'd100950468432347246,64'd98585398567354267,64'd96240434207686414,
    64'd93915378138939401,64'd91610043482856174,64'd89324253481539655,64'd87057841310153934,
    64'd84810649917778968,64'd82582531896296714,64'd80373349377406574,64'd78182973958099109,
    64'd76011286655163038,64'd73858177889566438,64'd71723547501844112,64'd69607304799945809,
    64'd67509368641361741,64'd65429667551751869,64'd63368139882774556,64'd61324734012351858,
    64'd59299408591239328,64'd57292132840508137,64'd55302886905421895,64'd53331662272231808,
    64'd51378462255661976,64'd49443302566363293,64'd47526211969445583,64'd45627233047438875,
    64'd43746423083797763,64'd41883855086494490,64'd40039618975542011,64'd38213822963709700,
    64'd36406595166596341,64'd34618085487094022,64'd32848467830786946,64'd31097942723928556,
    64'd29366740425678476,64'd27655124653209690,64'd25963397074986060,64'd24291902778257009,
    64'd22641036988180114,64'd21011253418202310,64'd19403074780780479,64'd17817106211110194,
    64'd16254052699851692,64'd14714742173886356,64'd13200156752949739,64'd11711476223803211,
    64'd10250140476027269,64'd8817942747959072,64'd7417175863422647,64'd6050876455905618,
    64'd4723268614579558,64'd3440671478981093,64'd2213728807329174,64'd1065027914558052
  };

  // Converts a decimal constant to fixed point with fb fraction bits, rounded to nearest.
  function automatic logic [63:0] dec_fix(logic [63:0] d, int unsigned fb);
    logic [63:0] q;
    logic [63:0] r;
    q = d / DEC_ONE;
    r = d % DEC_ONE;
    for (int unsigned i = 0; i < fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_ONE) begin
        r    = r - DEC_ONE;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= DEC_ONE) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  function automatic rom_t build_rom(dec_t dec, int unsigned fb);
    rom_t rom;
    for (int unsigned i = 0; i < NUM_LAYERS; i++) begin
      rom[i] = 32'(dec_fix(dec[i], fb));
    end
    return rom;
  endfunction

  // Layer edges x_k in Q4.28 and heights y_k in Q0.32.
  localparam rom_t X_ROM = build_rom(XDEC, 28);
  localparam rom_t Y_ROM = build_rom(YDEC, 32);

  localparam logic [31:0] TAIL_R   = X_ROM[NUM_LAYERS-1];
  localparam logic [31:0] Y_TOP    = Y_ROM[0];
  localparam logic [31:0] RECT_COEF = 32'(dec_fix(64'd927158602609581818, 32));
  localparam logic [63:0] TAIL_R64 = {32'd0, TAIL_R};
  localparam logic [63:0] TAIL_RR  = (TAIL_R64 * TAIL_R64) >> 28;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;

  // ceil(2^36 / k): floor(p * R / 2^36) equals floor(p / k) for every 32-bit p.
  // Division by 1 and by 2 is done by the datapath without the multiplier.
  typedef logic [MUL_W-1:0] recip_t [16];
  localparam recip_t RECIP = '{
    35'd0, 35'd0, 35'd0, 35'd22906492246, 35'd17179869184, 35'd13743895348,
    35'd11453246123, 35'd9817068106, 35'd8589934592, 35'd7635497416, 35'd6871947674,
    35'd6247225158, 35'd5726623062, 35'd5286113596, 35'd0, 35'd0
  };

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_CORE,
    OP_U_CORE,
    OP_MUL_WY,
    OP_WY,
    OP_MUL_UU,
    OP_T,
    OP_MUL_SH,
    OP_P,
    OP_MUL_PR,
    OP_H,
    OP_CAP,
    OP_MUL_HH,
    OP_HSQ,
    OP_MUL_G,
    OP_MUL_RECT,
    OP_U_RECT,
    OP_LOG_INIT,
    OP_NORM,
    OP_LOG_Y,
    OP_MUL_YY,
    OP_LOG_STEP,
    OP_MUL_LN,
    OP_ISQ_INIT,
    OP_ISQ_STEP,
    OP_U_TAIL,
    OP_MUL_TT,
    OP_TAIL_REJ,
    OP_MUL_OUT,
    OP_EMIT
  } zns_op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CORE_MUL,
    ST_CORE_U,
    ST_CORE_TEST,
    ST_WY_MUL,
    ST_WY,
    ST_UU_MUL,
    ST_T,
    ST_SH_MUL,
    ST_P,
    ST_PR_MUL,
    ST_H,
    ST_CAP,
    ST_HH_MUL,
    ST_HSQ,
    ST_G_MUL,
    ST_WEDGE_TEST,
    ST_RECT_MUL,
    ST_RECT_U,
    ST_LOG_INIT,
    ST_NORM,
    ST_LOG_Y,
    ST_YY_MUL,
    ST_LOG_STEP,
    ST_LN_MUL,
    ST_ISQ_INIT,
    ST_ISQ_STEP,
    ST_U_TAIL,
    ST_TT_MUL,
    ST_TAIL_TEST,
    ST_OUT_MUL,
    ST_EMIT
  } zns_state_e;

  typedef struct packed {
    zns_op_e     op;
    logic [3:0]  k;
  } zns_cmd_t;

  typedef struct packed {
    logic pending;
    logic bottom;
    logic rect;
    logic core_in;
    logic wedge_rej;
    logic norm_done;
    logic tail_rej;
  } zns_stat_t;

  typedef struct packed {
    logic [31:0] sample;
    logic [31:0] core_sample;
    logic        saturated;
  } zns_result_t;

endpackage

// ===== sv/ziggurat_normal_sampler.sv =====
// Top level of the ziggurat normal sampler: configuration, controller, datapath, output register.
// Paths of a trial: a layer-core hit, a rectangle draw, a wedge trial and a tail trial, the last with
// up to 32 normalize steps, 28 log squarings and 32 square-root steps; all share one 35x35 multiplier.
// One trial is in flight at a time; the next input beat is taken in the cycle after the result is
// loaded, a rejected trial gives none.
// Reset (rst_ni low, asynchronous) clears controller and tail flags, mean to 0, spread to 1.0.
module ziggurat_normal_sampler import zns_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           layer_byte_i,
  input  logic [31:0]          uniform_a_i,
  input  logic [31:0]          uniform_b_i,
  input  logic [31:0]          uniform_c_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          sample_o,
  output logic [31:0]          core_sample_o,
  output logic                 saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [31:0]  mean_q, spread_q;
  zns_cmd_t     cmd;
  zns_stat_t    stat;
  zns_result_t  result;
  zns_result_t  out_q;
  logic         out_valid_q;
  logic         out_free;
  logic         busy;

  // Configuration writes are always taken; the user must issue them only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      spread_q <= SPREAD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MEAN:   mean_q   <= cfg_data_i;
        REG_SPREAD: spread_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The output register frees the controller: a new trial may start while a beat waits here.
  assign out_free = !out_valid_q || !out_stall_i;

  zns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  zns_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .layer_byte_i (layer_byte_i),
    .uniform_a_i  (uniform_a_i),
    .uniform_b_i  (uniform_b_i),
    .uniform_c_i  (uniform_c_i),
    .mean_i       (mean_q),
    .spread_i     (spread_q),
    .stat_o       (stat),
    .result_o     (result)
  );

  assign in_stall_o = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == OP_EMIT) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = out_q.sample;
  assign core_sample_o = out_q.core_sample;
  assign saturated_o   = out_q.saturated;

  // A result is only loaded when the waiting beat has gone or is leaving.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EMIT) |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting output beat");

  // An accepted input beat keeps the input stalled in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A clipped sample sits on one of the 32-bit bounds.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (sample_o == 32'h7FFF_FFFF || sample_o == 32'h8000_0000))
    else $error("saturated sample not at a bound");

  // A tail rejection leaves the pending flag set on the next cycle.
  a_tail_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_TAIL_REJ) |=> stat.pending)
    else $error("tail rejection did not set pending");

endmodule

// ===== sv/zns_dp.sv =====
// Datapath of the ziggurat normal sampler: shared multiplier, trial registers and result logic.
module zns_dp import zns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zns_cmd_t         cmd_i,
  input  logic [7:0]       layer_byte_i,
  input  logic [31:0]      uniform_a_i,
  input  logic [31:0]      uniform_b_i,
  input  logic [31:0]      uniform_c_i,
  input  logic [31:0]      mean_i,
  input  logic [31:0]      spread_i,
  output zns_stat_t        stat_o,
  output zns_result_t      result_o
);

  logic                sign_q;
  logic [LAYER_W-1:0]  k_q;
  logic [LAYER_W-1:0]  k_nx;
  logic [31:0]         ua_q, ub_q, uc_q;
  logic [31:0]         u_q;
  logic [31:0]         y_q;
  logic [31:0]         s_q;
  logic [32:0]         h_q;
  logic [32:0]         w_q;
  logic [5:0]          p_q;
  logic [27:0]         f_q;
  logic [63:0]         v_q, res_q, bit_q;
  logic [PROD_W-1:0]   prod_q;
  logic                pend_q, held_q;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                is_mul;
  logic [33:0]         l2;
  logic [31:0]         quo;
  logic [31:0]         sq_t;
  logic [63:0]         isq_sum;
  logic [63:0]         isq_s;

  assign k_nx = k_q + LAYER_W'(1);
  assign l2   = {(6'd32 - p_q), 28'd0} - {6'd0, f_q};
  // Division by 1 and 2 needs no multiply; larger divisors use the reciprocal product.
  assign quo  = (cmd_i.k == 4'd1) ? w_q[31:0] :
                (cmd_i.k == 4'd2) ? {1'b0, w_q[31:1]} : prod_q[67:36];
  assign sq_t = prod_q[61:30];
  assign isq_sum = res_q + bit_q;
  assign isq_s   = TAIL_RR + {29'd0, prod_q[63:29]};

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    case (cmd_i.op)
      OP_MUL_CORE: begin
        mul_a = MUL_W'(X_ROM[k_nx]);
        mul_b = MUL_W'(ua_q);
      end
      OP_MUL_WY: begin
        mul_a = MUL_W'(Y_ROM[k_q] - Y_ROM[k_nx]);
        mul_b = MUL_W'(ub_q);
      end
      OP_MUL_UU: begin
        mul_a = MUL_W'(u_q);
        mul_b = MUL_W'(u_q);
      end
      OP_MUL_SH: begin
        mul_a = MUL_W'(s_q);
        mul_b = MUL_W'(h_q);
      end
      OP_MUL_PR: begin
        mul_a = MUL_W'(w_q[31:0]);
        mul_b = RECIP[cmd_i.k];
      end
      OP_MUL_HH: begin
        mul_a = MUL_W'(h_q);
        mul_b = MUL_W'(h_q);
      end
      OP_MUL_G: begin
        mul_a = MUL_W'(Y_TOP);
        mul_b = MUL_W'(h_q);
      end
      OP_MUL_RECT: begin
        mul_a = MUL_W'(TAIL_R);
        mul_b = MUL_W'(ub_q);
      end
      OP_MUL_YY: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      OP_MUL_LN: begin
        mul_a = MUL_W'(l2);
        mul_b = MUL_W'(LN2_Q30);
      end
      OP_MUL_TT: begin
        mul_a = MUL_W'(u_q);
        mul_b = MUL_W'(ub_q);
      end
      OP_MUL_OUT: begin
        mul_a = MUL_W'(spread_i);
        mul_b = MUL_W'(u_q);
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (is_mul) begin
      prod_q <= mul_p;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        ua_q <= uniform_a_i;
        ub_q <= uniform_b_i;
        uc_q <= uniform_c_i;
        if (pend_q) begin
          sign_q <= held_q;
        end else begin
          sign_q <= layer_byte_i[7];
          k_q    <= layer_byte_i[LAYER_W-1:0];
        end
      end
      OP_U_CORE, OP_U_RECT: u_q <= prod_q[63:32];
      OP_WY: y_q <= Y_ROM[k_nx] + prod_q[63:32];
      OP_T: begin
        s_q <= prod_q[60:29];
        h_q <= 33'h1_0000_0000;
      end
      OP_P: w_q <= {1'b0, prod_q[63:32]};
      OP_H: h_q <= 33'h1_0000_0000 - {1'b0, quo};
      OP_CAP: begin
        if (h_q[32]) begin
          h_q <= {1'b0, 32'hFFFF_FFFF};
        end
      end
      OP_HSQ: h_q <= {1'b0, prod_q[63:32]};
      OP_LOG_INIT: begin
        w_q <= 33'h1_0000_0000 - {1'b0, uc_q};
        p_q <= 6'd32;
      end
      OP_NORM: begin
        w_q <= {w_q[31:0], 1'b0};
        p_q <= p_q - 6'd1;
      end
      OP_LOG_Y: begin
        y_q <= {1'b0, w_q[32:2]};
        f_q <= '0;
      end
      OP_LOG_STEP: begin
        if (sq_t[31]) begin
          y_q <= {1'b0, sq_t[31:1]};
          f_q <= {f_q[26:0], 1'b1};
        end else begin
          y_q <= sq_t;
          f_q <= {f_q[26:0], 1'b0};
        end
      end
      OP_ISQ_INIT: begin
        v_q   <= isq_s << 28;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_ISQ_STEP: begin
        if (v_q >= isq_sum) begin
          v_q   <= v_q - isq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_U_TAIL: u_q <= res_q[31:0];
      default: ;
    endcase
  end

  // Tail state survives between beats and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= 1'b0;
    end else if (cmd_i.op == OP_TAIL_REJ) begin
      pend_q <= 1'b1;
      held_q <= sign_q;
    end else if (cmd_i.op == OP_EMIT) begin
      pend_q <= 1'b0;
    end
  end

  assign stat_o.pending   = pend_q;
  assign stat_o.bottom    = (k_q == LAST_LAYER);
  assign stat_o.rect      = (ua_q <= RECT_COEF);
  assign stat_o.core_in   = (u_q <= X_ROM[k_q]);
  assign stat_o.wedge_rej = (y_q > prod_q[63:32]);
  assign stat_o.norm_done = w_q[32];
  assign stat_o.tail_rej  = (prod_q[63:32] > TAIL_R);

  // Scaled sample: mean plus or minus the truncated magnitude, clipped to 32 bits.
  logic [35:0]        mag;
  logic signed [37:0] tot;
  logic               ovf;

  assign mag = prod_q[63:28];
  assign tot = sign_q ? ($signed({{6{mean_i[31]}}, mean_i}) + $signed({2'b00, mag}))
                      : ($signed({{6{mean_i[31]}}, mean_i}) - $signed({2'b00, mag}));
  assign ovf = !((&tot[37:31]) || !(|tot[37:31]));

  assign result_o.saturated   = ovf;
  assign result_o.sample      = ovf ? (tot[37] ? 32'h8000_0000 : 32'h7FFF_FFFF) : tot[31:0];
  assign result_o.core_sample = sign_q ? u_q : (32'd0 - u_q);

endmodule

// ===== sv/zns_ctrl.sv =====
// Controller state machine that sequences one ziggurat trial through the datapath.
module zns_ctrl import zns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_free_i,
  input  zns_stat_t  stat_i,
  output zns_cmd_t   cmd_o,
  output logic       busy_o
);

  zns_state_e  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o.op = OP_NOP;
    cmd_o.k  = cnt_q[3:0];
    busy_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.pending) begin
          state_d = ST_LOG_INIT;
        end else if (!stat_i.bottom) begin
          state_d = ST_CORE_MUL;
        end else if (stat_i.rect) begin
          state_d = ST_RECT_MUL;
        end else begin
          state_d = ST_LOG_INIT;
        end
      end
      ST_CORE_MUL: begin
        cmd_o.op = OP_MUL_CORE;
        state_d  = ST_CORE_U;
      end
      ST_CORE_U: begin
        cmd_o.op = OP_U_CORE;
        state_d  = ST_CORE_TEST;
      end
      ST_CORE_TEST: begin
        state_d = stat_i.core_in ? ST_OUT_MUL : ST_WY_MUL;
      end
      ST_WY_MUL: begin
        cmd_o.op = OP_MUL_WY;
        state_d  = ST_WY;
      end
      ST_WY: begin
        cmd_o.op = OP_WY;
        state_d  = ST_UU_MUL;
      end
      ST_UU_MUL: begin
        cmd_o.op = OP_MUL_UU;
        state_d  = ST_T;
      end
      ST_T: begin
        cmd_o.op = OP_T;
        cnt_d    = 6'd13;
        state_d  = ST_SH_MUL;
      end
      ST_SH_MUL: begin
        cmd_o.op = OP_MUL_SH;
        state_d  = ST_P;
      end
      ST_P: begin
        cmd_o.op = OP_P;
        state_d  = (cnt_q <= 6'd2) ? ST_H : ST_PR_MUL;
      end
      ST_PR_MUL: begin
        cmd_o.op = OP_MUL_PR;
        state_d  = ST_H;
      end
      ST_H: begin
        cmd_o.op = OP_H;
        if (cnt_q == 6'd1) begin
          state_d = ST_CAP;
        end else begin
          cnt_d   = cnt_q - 6'd1;
          state_d = ST_SH_MUL;
        end
      end
      ST_CAP: begin
        cmd_o.op = OP_CAP;
        cnt_d    = 6'd4;
        state_d  = ST_HH_MUL;
      end
      ST_HH_MUL: begin
        cmd_o.op = OP_MUL_HH;
        state_d  = ST_HSQ;
      end
      ST_HSQ: begin
        cmd_o.op = OP_HSQ;
        cnt_d    = cnt_q - 6'd1;
        state_d  = (cnt_q == 6'd1) ? ST_G_MUL : ST_HH_MUL;
      end
      ST_G_MUL: begin
        cmd_o.op = OP_MUL_G;
        state_d  = ST_WEDGE_TEST;
      end
      ST_WEDGE_TEST: begin
        state_d = stat_i.wedge_rej ? ST_IDLE : ST_OUT_MUL;
      end
      ST_RECT_MUL: begin
        cmd_o.op = OP_MUL_RECT;
        state_d  = ST_RECT_U;
      end
      ST_RECT_U: begin
        cmd_o.op = OP_U_RECT;
        state_d  = ST_OUT_MUL;
      end
      ST_LOG_INIT: begin
        cmd_o.op = OP_LOG_INIT;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        if (stat_i.norm_done) begin
          state_d = ST_LOG_Y;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      ST_LOG_Y: begin
        cmd_o.op = OP_LOG_Y;
        cnt_d    = 6'd28;
        state_d  = ST_YY_MUL;
      end
      ST_YY_MUL: begin
        cmd_o.op = OP_MUL_YY;
        state_d  = ST_LOG_STEP;
      end
      ST_LOG_STEP: begin
        cmd_o.op = OP_LOG_STEP;
        cnt_d    = cnt_q - 6'd1;
        state_d  = (cnt_q == 6'd1) ? ST_LN_MUL : ST_YY_MUL;
      end
      ST_LN_MUL: begin
        cmd_o.op = OP_MUL_LN;
        state_d  = ST_ISQ_INIT;
      end
      ST_ISQ_INIT: begin
        cmd_o.op = OP_ISQ_INIT;
        cnt_d    = 6'd32;
        state_d  = ST_ISQ_STEP;
      end
      ST_ISQ_STEP: begin
        cmd_o.op = OP_ISQ_STEP;
        cnt_d    = cnt_q - 6'd1;
        state_d  = (cnt_q == 6'd1) ? ST_U_TAIL : ST_ISQ_STEP;
      end
      ST_U_TAIL: begin
        cmd_o.op = OP_U_TAIL;
        state_d  = ST_TT_MUL;
      end
      ST_TT_MUL: begin
        cmd_o.op = OP_MUL_TT;
        state_d  = ST_TAIL_TEST;
      end
      ST_TAIL_TEST: begin
        if (stat_i.tail_rej) begin
          cmd_o.op = OP_TAIL_REJ;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_OUT_MUL;
        end
      end
      ST_OUT_MUL: begin
        cmd_o.op = OP_MUL_OUT;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
